// ----- sv/lrsi_pkg.sv -----
package lrsi_pkg;

    localparam int CFG_INDEX_W = 3;

    // Operand chunk width of the pipelined wide multipliers.
    localparam int MUL_CHUNK = 24;

    typedef enum logic [1:0] {
        OP_LINE    = 2'd0,
        OP_RAY     = 2'd1,
        OP_SEGMENT = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_CENTER_Z    = 3'd2,
        CFG_RADIUS      = 3'd3,
        CFG_TANGENT_EPS = 3'd4
    } cfg_reg_t;

endpackage

// ----- sv/line_ray_segment_sphere_intersect_unit.sv -----
// Channel   Direction  Handshake                  Payload
// s_        in         s_valid / s_ready          s_operation, s_start_*, s_aim_*
// m_        out        m_valid / m_ready          m_hit_count, m_t_*, m_first_*, m_second_*
// cfg_      in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item is taken every cycle unless a stall at m_ready holds the pipeline. Most of the stages are
// in the square root (one root bit per stage) and the two dividers (one quotient bit per stage).
// Reset is synchronous and clears only the stage valid bits and the centre and epsilon registers,
// and sets the radius to 1.0 (1 << FRAC_BITS). A stall at m_ready freezes every stage together;
// nothing is dropped.
module line_ray_segment_sphere_intersect_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_operation,
    input  logic signed [COORD_WIDTH-1:0]         s_start_x,
    input  logic signed [COORD_WIDTH-1:0]         s_start_y,
    input  logic signed [COORD_WIDTH-1:0]         s_start_z,
    input  logic signed [COORD_WIDTH-1:0]         s_aim_x,
    input  logic signed [COORD_WIDTH-1:0]         s_aim_y,
    input  logic signed [COORD_WIDTH-1:0]         s_aim_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_hit_count,
    output logic signed [COORD_WIDTH-1:0]         m_t_first,
    output logic signed [COORD_WIDTH-1:0]         m_t_second,
    output logic signed [COORD_WIDTH-1:0]         m_first_x,
    output logic signed [COORD_WIDTH-1:0]         m_first_y,
    output logic signed [COORD_WIDTH-1:0]         m_first_z,
    output logic signed [COORD_WIDTH-1:0]         m_second_x,
    output logic signed [COORD_WIDTH-1:0]         m_second_y,
    output logic signed [COORD_WIDTH-1:0]         m_second_z,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lrsi_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [(COORD_WIDTH > 32 ? COORD_WIDTH : 32)-1:0] cfg_data
);
    import lrsi_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DW   = W + 1;
    localparam int AW   = 2 * W + 2;
    localparam int HW   = 2 * W + 3;
    localparam int CW   = 2 * W + 3;
    localparam int MW   = 2 * W + 2;
    localparam int CH   = MUL_CHUNK;
    localparam int K    = (MW + CH - 1) / CH;
    localparam int KW   = K * CH;
    localparam int KK   = K * K;
    localparam int ACW  = 2 * KW;
    localparam int QB   = 4 * W;
    localparam int RB   = 2 * W + F;
    localparam int RW   = RB + 3;
    localparam int XW   = 2 * RB;
    localparam int TW   = (QB + 2 > 32 + 3 * F) ? QB + 2 : 32 + 3 * F;
    localparam int NW   = 2 * W + F + 4;
    localparam int NMW  = NW - 1;
    localparam int DVW  = NMW + W;
    localparam int PW   = DW + W;
    localparam int SW   = PW + 1;
    localparam int RADW = W - 1;

    localparam int ST_DEC = 7 + KK + RB + W;
    localparam int ST_PT  = ST_DEC + 1;
    localparam int NST    = ST_DEC + 3;

    localparam logic [W-1:0] T_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] T_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] T_ONE = (F >= W - 1) ? T_MAX : W'(64'd1 << F);

    typedef struct packed {
        logic [1:0]             op;
        logic                   a_zero;
        logic                   q_neg;
        logic                   tangent;
        logic [HW-1:0]          h;
        logic [AW-1:0]          a;
        logic [2:0][W-1:0]      s;
        logic [2:0][DW-1:0]     d;
    } side_t;

    // ---------------------------------------------------------------- control
    logic           ce;
    logic [NST-1:0] vld_reg;

    assign ce        = !vld_reg[NST-1] || m_ready;
    assign s_ready   = ce;
    assign m_valid   = vld_reg[NST-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // ---------------------------------------------------------------- sphere registers
    logic signed [W-1:0] center_reg [3];
    logic [RADW-1:0]     radius_reg;
    logic [31:0]         eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= RADW'(64'd1 << F);
            eps_reg       <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CENTER_X:    center_reg[0] <= cfg_data[W-1:0];
                CFG_CENTER_Y:    center_reg[1] <= cfg_data[W-1:0];
                CFG_CENTER_Z:    center_reg[2] <= cfg_data[W-1:0];
                CFG_RADIUS:      radius_reg    <= cfg_data[RADW-1:0];
                CFG_TANGENT_EPS: eps_reg       <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- stage 1: d and w
    logic signed [W-1:0]  in_s [3];
    logic signed [W-1:0]  in_aim [3];
    logic signed [DW-1:0] d_next [3];
    logic signed [DW-1:0] w_next [3];
    side_t                st1_next;
    side_t                st1_side_reg;
    logic signed [DW-1:0] st1_w_reg [3];

    assign in_s[0]   = s_start_x;
    assign in_s[1]   = s_start_y;
    assign in_s[2]   = s_start_z;
    assign in_aim[0] = s_aim_x;
    assign in_aim[1] = s_aim_y;
    assign in_aim[2] = s_aim_z;

    always_comb begin
        st1_next    = '0;
        st1_next.op = s_operation;
        for (int i = 0; i < 3; i++) begin
            if (s_operation == OP_SEGMENT) begin
                d_next[i] = in_aim[i] - in_s[i];
            end else begin
                d_next[i] = in_aim[i];
            end
            w_next[i]     = in_s[i] - center_reg[i];
            st1_next.s[i] = in_s[i];
            st1_next.d[i] = d_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st1_side_reg <= st1_next;
            st1_w_reg    <= w_next;
        end
    end

    // ---------------------------------------------------------------- stage 2: products
    logic signed [2*DW-1:0] p_dd [3];
    logic signed [2*DW-1:0] p_dw [3];
    logic signed [2*DW-1:0] p_ww [3];
    logic [2*RADW-1:0]      rr_next;
    side_t                  st2_side_reg;
    logic [2*W:0]           st2_dd_reg [3];
    logic signed [2*W+1:0]  st2_dw_reg [3];
    logic [2*W:0]           st2_ww_reg [3];
    logic [2*RADW-1:0]      st2_rr_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_dd[i] = $signed(st1_side_reg.d[i]) * $signed(st1_side_reg.d[i]);
            p_dw[i] = $signed(st1_side_reg.d[i]) * st1_w_reg[i];
            p_ww[i] = st1_w_reg[i] * st1_w_reg[i];
        end
        rr_next = radius_reg * radius_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st2_side_reg <= st1_side_reg;
            st2_rr_reg   <= rr_next;
            for (int i = 0; i < 3; i++) begin
                st2_dd_reg[i] <= p_dd[i][2*W:0];
                st2_dw_reg[i] <= p_dw[i][2*W+1:0];
                st2_ww_reg[i] <= p_ww[i][2*W:0];
            end
        end
    end

    // ---------------------------------------------------------------- stage 3: A, H, C
    logic [AW-1:0]        a_next;
    logic signed [HW-1:0] h_next;
    logic signed [CW-1:0] c_next;
    side_t                st3_next;
    side_t                st3_side_reg;
    logic signed [CW-1:0] st3_c_reg;

    always_comb begin
        a_next = AW'(st2_dd_reg[0]) + AW'(st2_dd_reg[1]) + AW'(st2_dd_reg[2]);
        h_next = st2_dw_reg[0] + st2_dw_reg[1] + st2_dw_reg[2];
        c_next = $signed(CW'(st2_ww_reg[0])) + $signed(CW'(st2_ww_reg[1]))
               + $signed(CW'(st2_ww_reg[2])) - $signed(CW'(st2_rr_reg));
        st3_next   = st2_side_reg;
        st3_next.a = a_next;
        st3_next.h = h_next;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st3_side_reg <= st3_next;
            st3_c_reg    <= c_next;
        end
    end

    // ---------------------------------------------------------------- stage 4: magnitudes
    logic signed [HW-1:0] h_neg;
    logic signed [CW-1:0] c_neg_val;
    side_t                st4_next;
    side_t                st4_side_reg;
    logic [MW-1:0]        st4_hm_reg;
    logic [MW-1:0]        st4_cm_reg;
    logic                 st4_cneg_reg;

    assign h_neg     = -$signed(st3_side_reg.h);
    assign c_neg_val = -st3_c_reg;

    always_comb begin
        st4_next        = st3_side_reg;
        st4_next.a_zero = (st3_side_reg.a == '0);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st4_side_reg <= st4_next;
            st4_hm_reg   <= st3_side_reg.h[HW-1] ? h_neg[MW-1:0] : st3_side_reg.h[MW-1:0];
            st4_cm_reg   <= st3_c_reg[CW-1] ? c_neg_val[MW-1:0] : st3_c_reg[MW-1:0];
            st4_cneg_reg <= st3_c_reg[CW-1];
        end
    end

    // ---------------------------------------------------------------- H*H and A*|C|
    // One chunk-by-chunk partial product of each per stage.
    side_t          mul_side_reg [KK];
    logic [MW-1:0]  mul_hm_reg [KK];
    logic [MW-1:0]  mul_cm_reg [KK];
    logic           mul_cneg_reg [KK];
    logic [ACW-1:0] mul_hh_reg [KK];
    logic [ACW-1:0] mul_ac_reg [KK];

    for (genvar k = 0; k < KK; k++) begin : g_mul
        localparam int I = k / K;
        localparam int J = k % K;
        side_t          src_side;
        logic [MW-1:0]  src_hm;
        logic [MW-1:0]  src_cm;
        logic           src_cneg;
        logic [ACW-1:0] src_hh;
        logic [ACW-1:0] src_ac;
        logic [KW-1:0]  hm_pad;
        logic [KW-1:0]  cm_pad;
        logic [KW-1:0]  a_pad;
        logic [2*CH-1:0] pp_hh;
        logic [2*CH-1:0] pp_ac;

        if (k == 0) begin : g_first
            assign src_side = st4_side_reg;
            assign src_hm   = st4_hm_reg;
            assign src_cm   = st4_cm_reg;
            assign src_cneg = st4_cneg_reg;
            assign src_hh   = '0;
            assign src_ac   = '0;
        end else begin : g_chain
            assign src_side = mul_side_reg[k-1];
            assign src_hm   = mul_hm_reg[k-1];
            assign src_cm   = mul_cm_reg[k-1];
            assign src_cneg = mul_cneg_reg[k-1];
            assign src_hh   = mul_hh_reg[k-1];
            assign src_ac   = mul_ac_reg[k-1];
        end

        assign hm_pad = KW'(src_hm);
        assign cm_pad = KW'(src_cm);
        assign a_pad  = KW'(src_side.a);
        assign pp_hh  = hm_pad[I*CH +: CH] * hm_pad[J*CH +: CH];
        assign pp_ac  = a_pad[I*CH +: CH] * cm_pad[J*CH +: CH];

        always_ff @(posedge aclk) begin
            if (ce) begin
                mul_side_reg[k] <= src_side;
                mul_hm_reg[k]   <= src_hm;
                mul_cm_reg[k]   <= src_cm;
                mul_cneg_reg[k] <= src_cneg;
                mul_hh_reg[k]   <= src_hh + (ACW'(pp_hh) << (CH * (I + J)));
                mul_ac_reg[k]   <= src_ac + (ACW'(pp_ac) << (CH * (I + J)));
            end
        end
    end

    // ---------------------------------------------------------------- Q = H*H - A*C
    logic [ACW-1:0] q_sum;
    logic [ACW-1:0] q_diff;
    side_t          stq_next;
    side_t          stq_side_reg;
    logic [QB-1:0]  stq_q_reg;

    assign q_sum  = mul_hh_reg[KK-1] + mul_ac_reg[KK-1];
    assign q_diff = mul_hh_reg[KK-1] - mul_ac_reg[KK-1];

    always_comb begin
        stq_next       = mul_side_reg[KK-1];
        stq_next.q_neg = !mul_cneg_reg[KK-1] && (mul_hh_reg[KK-1] < mul_ac_reg[KK-1]);
    end

    // A non-negative Q never exceeds A*r^2, so 4*COORD_WIDTH bits hold it.
    always_ff @(posedge aclk) begin
        if (ce) begin
            stq_side_reg <= stq_next;
            stq_q_reg    <= mul_cneg_reg[KK-1] ? q_sum[QB-1:0] : q_diff[QB-1:0];
        end
    end

    // ---------------------------------------------------------------- tangent test
    side_t         stt_next;
    side_t         stt_side_reg;
    logic [QB-1:0] stt_q_reg;

    always_comb begin
        stt_next         = stq_side_reg;
        stt_next.tangent = ((TW'(stq_q_reg) << 2) < (TW'(eps_reg) << (3 * F)));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            stt_side_reg <= stt_next;
            stt_q_reg    <= stq_q_reg;
        end
    end

    // ---------------------------------------------------------------- square root of Q*S^2
    side_t         sq_side_reg [RB];
    logic [RW-1:0] sq_rem_reg [RB];
    logic [RB-1:0] sq_root_reg [RB];
    logic [XW-1:0] sq_x_reg [RB];

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        side_t         src_side;
        logic [RW-1:0] src_rem;
        logic [RB-1:0] src_root;
        logic [XW-1:0] src_x;
        logic [RW-1:0] r2;
        logic [RW-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign src_side = stt_side_reg;
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_x    = XW'(stt_q_reg) << (2 * F);
        end else begin : g_chain
            assign src_side = sq_side_reg[k-1];
            assign src_rem  = sq_rem_reg[k-1];
            assign src_root = sq_root_reg[k-1];
            assign src_x    = sq_x_reg[k-1];
        end

        assign r2    = {src_rem[RW-3:0], src_x[XW-1 -: 2]};
        assign trial = RW'({src_root, 2'b01});
        assign ge    = (r2 >= trial);

        always_ff @(posedge aclk) begin
            if (ce) begin
                sq_side_reg[k] <= src_side;
                sq_rem_reg[k]  <= ge ? r2 - trial : r2;
                sq_root_reg[k] <= {src_root[RB-2:0], ge};
                sq_x_reg[k]    <= src_x << 2;
            end
        end
    end

    // ---------------------------------------------------------------- numerators
    logic signed [NW-1:0] hs;
    logic signed [NW-1:0] root_s;
    side_t                dv0_side_reg;
    logic signed [NW-1:0] dv0_n_reg [2];

    always_comb begin
        hs     = $signed(sq_side_reg[RB-1].h);
        hs     = hs <<< F;
        root_s = NW'(sq_root_reg[RB-1]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv0_side_reg <= sq_side_reg[RB-1];
            dv0_n_reg[0] <= -hs - root_s;
            dv0_n_reg[1] <= -hs + root_s;
        end
    end

    // ---------------------------------------------------------------- divider setup
    // Floor division of a negative numerator runs on its complement: floor(-m/A) = ~floor((m-1)/A).
    side_t          dv1_side_reg;
    logic [NMW-1:0] dv1_m_reg [2];
    logic           dv1_neg_reg [2];
    logic           dv1_ovf_reg [2];
    logic [NMW-1:0] m_next [2];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            m_next[j] = dv0_n_reg[j][NW-1] ? ~dv0_n_reg[j][NMW-1:0] : dv0_n_reg[j][NMW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv1_side_reg <= dv0_side_reg;
            for (int j = 0; j < 2; j++) begin
                dv1_m_reg[j]   <= m_next[j];
                dv1_neg_reg[j] <= dv0_n_reg[j][NW-1];
                dv1_ovf_reg[j] <= (DVW'(m_next[j]) >= (DVW'(dv0_side_reg.a) << (W - 1)));
            end
        end
    end

    // ---------------------------------------------------------------- restoring dividers
    side_t          dq_side_reg [W-1];
    logic [NMW-1:0] dq_rem_reg [W-1][2];
    logic [W-2:0]   dq_q_reg [W-1][2];
    logic           dq_neg_reg [W-1][2];
    logic           dq_ovf_reg [W-1][2];

    for (genvar k = 0; k < W - 1; k++) begin : g_div
        localparam int B = W - 2 - k;
        side_t          src_side;
        logic [NMW-1:0] src_rem [2];
        logic [W-2:0]   src_q [2];
        logic           src_neg [2];
        logic           src_ovf [2];
        logic           ge [2];
        logic [DVW-1:0] sub [2];

        if (k == 0) begin : g_first
            assign src_side = dv1_side_reg;
            assign src_rem  = dv1_m_reg;
            assign src_neg  = dv1_neg_reg;
            assign src_ovf  = dv1_ovf_reg;
            assign src_q[0] = '0;
            assign src_q[1] = '0;
        end else begin : g_chain
            assign src_side = dq_side_reg[k-1];
            assign src_rem  = dq_rem_reg[k-1];
            assign src_q    = dq_q_reg[k-1];
            assign src_neg  = dq_neg_reg[k-1];
            assign src_ovf  = dq_ovf_reg[k-1];
        end

        for (genvar j = 0; j < 2; j++) begin : g_lane
            assign ge[j]  = ((DVW'(src_rem[j]) >> B) >= DVW'(src_side.a));
            assign sub[j] = DVW'(src_rem[j]) - (DVW'(src_side.a) << B);

            always_ff @(posedge aclk) begin
                if (ce) begin
                    dq_rem_reg[k][j] <= ge[j] ? sub[j][NMW-1:0] : src_rem[j];
                    dq_q_reg[k][j]   <= {src_q[j][W-3:0], ge[j]};
                    dq_neg_reg[k][j] <= src_neg[j];
                    dq_ovf_reg[k][j] <= src_ovf[j];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                dq_side_reg[k] <= src_side;
            end
        end
    end

    // ---------------------------------------------------------------- hit decision
    logic signed [W-1:0] t_sat [2];
    logic signed [W-1:0] t1_next;
    logic signed [W-1:0] t2_next;
    logic [1:0]          n_next;
    side_t               dec_side;
    side_t               dec_side_reg;
    logic [1:0]          dec_n_reg;
    logic signed [W-1:0] dec_t_reg [2];

    assign dec_side = dq_side_reg[W-2];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            if (dq_ovf_reg[W-2][j]) begin
                t_sat[j] = dq_neg_reg[W-2][j] ? T_MIN : T_MAX;
            end else if (dq_neg_reg[W-2][j]) begin
                t_sat[j] = ~{1'b0, dq_q_reg[W-2][j]};
            end else begin
                t_sat[j] = {1'b0, dq_q_reg[W-2][j]};
            end
        end
        t1_next = t_sat[0];
        t2_next = t_sat[1];
        n_next  = 2'd0;
        if (dec_side.a_zero || dec_side.q_neg) begin
            n_next = 2'd0;
        end else if (dec_side.op == OP_LINE) begin
            n_next = dec_side.tangent ? 2'd1 : 2'd2;
        end else if (dec_side.op == OP_RAY) begin
            if (dec_side.tangent) begin
                n_next = (t1_next < 0) ? 2'd0 : 2'd1;
            end else if (t2_next < 0) begin
                n_next = 2'd0;
            end else begin
                n_next = 2'd2;
                if (t1_next < 0) begin
                    t1_next = '0;
                end
            end
        end else if (dec_side.op == OP_SEGMENT) begin
            if (dec_side.tangent) begin
                n_next = (t1_next < 0 || t1_next > $signed(T_ONE)) ? 2'd0 : 2'd1;
            end else if (t2_next < 0 || t1_next > $signed(T_ONE)) begin
                n_next = 2'd0;
            end else begin
                n_next = 2'd2;
                if (t1_next < 0) begin
                    t1_next = '0;
                end
                if (t2_next > $signed(T_ONE)) begin
                    t2_next = T_ONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dec_side_reg <= dec_side;
            dec_n_reg    <= n_next;
            dec_t_reg[0] <= t1_next;
            dec_t_reg[1] <= t2_next;
        end
    end

    // ---------------------------------------------------------------- d*t for the points
    logic [1:0]           pt_n_reg;
    logic signed [W-1:0]  pt_t_reg [2];
    logic [2:0][W-1:0]    pt_s_reg;
    logic signed [PW-1:0] pt_prod_reg [2][3];

    always_ff @(posedge aclk) begin
        if (ce) begin
            pt_n_reg <= dec_n_reg;
            pt_t_reg <= dec_t_reg;
            pt_s_reg <= dec_side_reg.s;
            for (int j = 0; j < 2; j++) begin
                for (int i = 0; i < 3; i++) begin
                    pt_prod_reg[j][i] <= $signed(dec_side_reg.d[i]) * dec_t_reg[j];
                end
            end
        end
    end

    // ---------------------------------------------------------------- output register
    logic signed [PW-1:0] pt_sh [2][3];
    logic signed [SW-1:0] pt_sum [2][3];
    logic signed [W-1:0]  pt_next [2][3];
    logic [1:0]           out_n_reg;
    logic signed [W-1:0]  out_t_reg [2];
    logic signed [W-1:0]  out_pt_reg [2][3];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
                pt_sh[j][i]  = pt_prod_reg[j][i] >>> F;
                pt_sum[j][i] = pt_sh[j][i] + $signed(pt_s_reg[i]);
                if (pt_sum[j][i][SW-1:W-1] != {(SW-W+1){pt_sum[j][i][SW-1]}}) begin
                    pt_next[j][i] = pt_sum[j][i][SW-1] ? T_MIN : T_MAX;
                end else begin
                    pt_next[j][i] = pt_sum[j][i][W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_n_reg    <= pt_n_reg;
            out_t_reg[0] <= (pt_n_reg != 2'd0) ? pt_t_reg[0] : '0;
            out_t_reg[1] <= (pt_n_reg == 2'd2) ? pt_t_reg[1] : '0;
            for (int i = 0; i < 3; i++) begin
                out_pt_reg[0][i] <= (pt_n_reg != 2'd0) ? pt_next[0][i] : '0;
                out_pt_reg[1][i] <= (pt_n_reg == 2'd2) ? pt_next[1][i] : '0;
            end
        end
    end

    assign m_hit_count = out_n_reg;
    assign m_t_first   = out_t_reg[0];
    assign m_t_second  = out_t_reg[1];
    assign m_first_x   = out_pt_reg[0][0];
    assign m_first_y   = out_pt_reg[0][1];
    assign m_first_z   = out_pt_reg[0][2];
    assign m_second_x  = out_pt_reg[1][0];
    assign m_second_y  = out_pt_reg[1][1];
    assign m_second_z  = out_pt_reg[1][2];

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hit_count != 2'd3)
        else $error("hit count out of range");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit_count == 2'd0 |-> m_t_first == '0 && m_first_x == '0
            && m_first_y == '0 && m_first_z == '0)
        else $error("miss carries nonzero entry fields");

    a_second_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit_count != 2'd2 |-> m_t_second == '0 && m_second_x == '0
            && m_second_y == '0 && m_second_z == '0)
        else $error("second hit fields set without a second hit");

    a_t_order: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_PT] && pt_n_reg == 2'd2 |-> pt_t_reg[0] <= pt_t_reg[1])
        else $error("entry parameter above exit parameter");

    a_ray_front: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_DEC] && dec_side_reg.op == OP_RAY && dec_n_reg != 2'd0
            |-> dec_t_reg[0] >= 0)
        else $error("ray hit behind the origin");
`endif

endmodule
